### hw/rtl/twq_pkg.sv
package twq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int TICK_BITS_DEF   = 16;

	typedef enum logic [1:0] {
		FUNC_PUT  = 2'd0,
		FUNC_GET  = 2'd1,
		FUNC_TICK = 2'd2
	} twq_func_t;

	typedef enum logic [2:0] {
		ST_PUT_OK   = 3'd0,
		ST_PUT_FULL = 3'd1,
		ST_GOT      = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_RELEASE  = 3'd4,
		ST_NONE     = 3'd5
	} twq_status_t;

	typedef struct packed {
		twq_func_t   func;
		logic [7:0]  task_id;
		logic [15:0] wait_ticks;
	} twq_cmd_t;

	typedef struct packed {
		twq_status_t status;
		logic [7:0]  out_task;
		logic [4:0]  queue_count;
		logic        last;
	} twq_rsp_t;

endpackage

### hw/rtl/timed_wait_queue_unit.sv
// Timed wait queue of a counting semaphore: a FIFO of blocked task ids, each
// with an optional tick timeout (zero means wait without limit).
//
// Command channel: a transaction is taken at a rising edge with start high
// and busy low. cmd.func selects put, get or tick; func value three is
// ignored and gives no result.
// Result channel: each result sits on rsp for exactly one cycle with strobe
// high. The receiver cannot stall it. rsp.last marks the final result of a
// command; rsp.queue_count is the number of waiting entries after it.
//
// Timing: put, full put, empty get and tick on an empty queue answer in the
// cycle after the command. Get and tick walk the n waiting entries through
// the slot memory, one entry a cycle over its single registered read port
// and single write port. Busy stays high over the walk. A tick emits one
// result per expired entry, in queue order, while it compacts the survivors,
// or a single none result if no entry expires.
// Reset clears the entry count and the sequencer; the slot memory needs no
// clearing since only data read from slots below the count is ever used.
module timed_wait_queue_unit
	import twq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int TICK_BITS   = TICK_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  twq_cmd_t cmd,
	output logic     busy,
	output logic     strobe,
	output twq_rsp_t rsp
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WALK = 3'b010,
		S_DONE = 3'b100
	} state_t;

	function automatic logic [4:0] count5(input logic [CNT_W-1:0] c);
		logic [CNT_W+4:0] ext;
		ext = {5'b0, c};
		return ext[4:0];
	endfunction

	// slot memory: task ids and remaining ticks, slot 0 oldest
	logic [7:0]           task_mem  [QUEUE_DEPTH];
	logic [TICK_BITS-1:0] ticks_mem [QUEUE_DEPTH];
	logic [7:0]           rd_task_q;
	logic [TICK_BITS-1:0] rd_ticks_q;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;       // waiting entries
	logic [CNT_W-1:0] rd_idx_q;    // next slot to read
	logic [CNT_W-1:0] proc_idx_q;  // slot whose data is in rd_*_q
	logic [CNT_W-1:0] w_q;         // compaction write pointer
	logic [CNT_W-1:0] rem_q;       // entries left after releases so far
	logic             is_get_q;
	logic             pend_v_q;    // a result is held back until its last flag is known
	logic [7:0]       pend_task_q;
	logic             strobe_q;
	twq_rsp_t         rsp_q;

	logic [TICK_BITS+15:0] ticks_ext;
	logic [TICK_BITS-1:0]  put_ticks;
	logic                  full;
	logic                  walk_end;
	logic                  drop;
	logic [TICK_BITS-1:0]  new_ticks;
	logic [IDX_W-1:0]      rd_addr;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	logic [7:0]            wr_task;
	logic [TICK_BITS-1:0]  wr_ticks;

	assign ticks_ext = {{TICK_BITS{1'b0}}, cmd.wait_ticks};
	assign put_ticks = ticks_ext[TICK_BITS-1:0];
	assign full      = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign walk_end  = (proc_idx_q == cnt_q - CNT_W'(1));

	// get drops the head; tick drops entries whose count runs out now
	always_comb begin
		if (is_get_q) begin
			drop      = (proc_idx_q == '0);
			new_ticks = rd_ticks_q;
		end else begin
			drop      = (rd_ticks_q == TICK_BITS'(1));
			new_ticks = (rd_ticks_q != '0) ? rd_ticks_q - TICK_BITS'(1) : '0;
		end
	end

	assign rd_addr = (state_q == S_IDLE) ? '0 : rd_idx_q[IDX_W-1:0];

	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = w_q[IDX_W-1:0];
		wr_task  = rd_task_q;
		wr_ticks = new_ticks;
		if (state_q == S_IDLE) begin
			wr_en    = start && (cmd.func == FUNC_PUT) && !full;
			wr_addr  = cnt_q[IDX_W-1:0];
			wr_task  = cmd.task_id;
			wr_ticks = put_ticks;
		end else if (state_q == S_WALK) begin
			wr_en = !drop;
		end
	end

	// write address always trails the read address during a walk
	always_ff @(posedge clk) begin
		if (wr_en) begin
			task_mem[wr_addr]  <= wr_task;
			ticks_mem[wr_addr] <= wr_ticks;
		end
		rd_task_q  <= task_mem[rd_addr];
		rd_ticks_q <= ticks_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rd_idx_q    <= '0;
			proc_idx_q  <= '0;
			w_q         <= '0;
			rem_q       <= '0;
			is_get_q    <= 1'b0;
			pend_v_q    <= 1'b0;
			pend_task_q <= '0;
			strobe_q    <= 1'b0;
			rsp_q       <= '0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (cmd.func)
							FUNC_PUT: begin
								strobe_q      <= 1'b1;
								rsp_q.out_task <= '0;
								rsp_q.last    <= 1'b1;
								if (full) begin
									rsp_q.status      <= ST_PUT_FULL;
									rsp_q.queue_count <= count5(cnt_q);
								end else begin
									rsp_q.status      <= ST_PUT_OK;
									rsp_q.queue_count <= count5(cnt_q + CNT_W'(1));
									cnt_q             <= cnt_q + CNT_W'(1);
								end
							end
							FUNC_GET, FUNC_TICK: begin
								if (cnt_q == '0) begin
									strobe_q          <= 1'b1;
									rsp_q.status      <= (cmd.func == FUNC_GET) ?
										ST_EMPTY : ST_NONE;
									rsp_q.out_task    <= '0;
									rsp_q.queue_count <= '0;
									rsp_q.last        <= 1'b1;
								end else begin
									state_q    <= S_WALK;
									is_get_q   <= (cmd.func == FUNC_GET);
									rd_idx_q   <= CNT_W'(1);
									proc_idx_q <= '0;
									w_q        <= '0;
									rem_q      <= cnt_q;
									pend_v_q   <= 1'b0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_WALK: begin
					rd_idx_q   <= rd_idx_q + CNT_W'(1);
					proc_idx_q <= proc_idx_q + CNT_W'(1);
					if (drop) begin
						// flush the held release, it is not the last one
						if (pend_v_q) begin
							strobe_q          <= 1'b1;
							rsp_q.status      <= ST_RELEASE;
							rsp_q.out_task    <= pend_task_q;
							rsp_q.queue_count <= count5(rem_q);
							rsp_q.last        <= 1'b0;
						end
						pend_v_q    <= 1'b1;
						pend_task_q <= rd_task_q;
						rem_q       <= rem_q - CNT_W'(1);
					end else begin
						w_q <= w_q + CNT_W'(1);
					end
					if (walk_end) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					state_q           <= S_IDLE;
					cnt_q             <= w_q;
					strobe_q          <= 1'b1;
					rsp_q.queue_count <= count5(w_q);
					rsp_q.last        <= 1'b1;
					if (pend_v_q) begin
						rsp_q.status   <= is_get_q ? ST_GOT : ST_RELEASE;
						rsp_q.out_task <= pend_task_q;
					end else begin
						rsp_q.status   <= ST_NONE;
						rsp_q.out_task <= '0;
					end
					pend_v_q <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign rsp    = rsp_q;

endmodule

### bench/timed_wait_queue_unit_tb.sv
`timescale 1ns / 1ps

module timed_wait_queue_unit_tb;
	import twq_pkg::*;

	localparam int DEPTH = QUEUE_DEPTH_DEF;
	// func value three: the block ignores it and answers nothing
	localparam logic [1:0] FUNC_NOP = 2'd3;

	localparam int DIR_ROWS    = 25;
	localparam int RAND_ITEMS  = 145;
	localparam int QUIET_FROM  = 120;   // no sender gaps from this item on
	localparam int MAX_ERR_LOG = 10;

	// random traffic shapes
	localparam int MODE_CHURN = 0;
	localparam int MODE_FILL  = 1;
	localparam int MODE_DRAIN = 2;

	// one row of the directed table; known_rsp is used instead of the
	// predictor where the answer is obvious (single result)
	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  task_id;
		logic [15:0] wait_ticks;
		logic        has_known;
		twq_rsp_t    known_rsp;
	} stim_row_t;

	// one blocked task as the predictor keeps it
	typedef struct packed {
		logic [7:0]  task_id;
		logic [15:0] ticks;
	} waiter_t;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     start;
	twq_cmd_t cmd;
	logic     busy;
	logic     strobe;
	twq_rsp_t rsp;

	waiter_t   waiters[$];        // predicted queue contents, oldest first
	twq_rsp_t  expected_rsp[$];   // results still owed by the block
	stim_row_t dir_rows [DIR_ROWS];
	int        fail_count = 0;

	timed_wait_queue_unit #(
		.QUEUE_DEPTH(QUEUE_DEPTH_DEF),
		.TICK_BITS  (TICK_BITS_DEF)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cmd   (cmd),
		.busy  (busy),
		.strobe(strobe),
		.rsp   (rsp)
	);

	always #2 clk = ~clk;

	function automatic twq_rsp_t make_rsp(twq_status_t st, logic [7:0] tid, int cnt,
			logic lst);
		twq_rsp_t r;
		r.status      = st;
		r.out_task    = tid;
		r.queue_count = 5'(cnt);
		r.last        = lst;
		return r;
	endfunction

	// Queue behavior per command. Tick: every timed entry counts down; those
	// hitting zero leave in queue order, each with its own result, the count
	// dropping as they go. Survivors keep their order.
	function automatic void predict_queue(input twq_cmd_t c, output twq_rsp_t rsps[$]);
		waiter_t survivors[$];
		waiter_t w;
		int remaining;
		rsps = {};
		case (c.func)
			FUNC_PUT: begin
				if (waiters.size() >= DEPTH) begin
					rsps.push_back(make_rsp(ST_PUT_FULL, 8'd0, waiters.size(), 1'b1));
				end else begin
					w.task_id = c.task_id;
					w.ticks   = c.wait_ticks;
					waiters.push_back(w);
					rsps.push_back(make_rsp(ST_PUT_OK, 8'd0, waiters.size(), 1'b1));
				end
			end
			FUNC_GET: begin
				if (waiters.size() == 0) begin
					rsps.push_back(make_rsp(ST_EMPTY, 8'd0, 0, 1'b1));
				end else begin
					w = waiters.pop_front();
					rsps.push_back(make_rsp(ST_GOT, w.task_id, waiters.size(), 1'b1));
				end
			end
			FUNC_TICK: begin
				remaining = waiters.size();
				foreach (waiters[i]) begin
					w = waiters[i];
					if (w.ticks != 16'd0) begin
						w.ticks = w.ticks - 16'd1;
						if (w.ticks == 16'd0) begin
							remaining--;
							rsps.push_back(make_rsp(ST_RELEASE, w.task_id, remaining, 1'b0));
							continue;
						end
					end
					survivors.push_back(w);
				end
				waiters = survivors;
				if (rsps.size() == 0)
					rsps.push_back(make_rsp(ST_NONE, 8'd0, waiters.size(), 1'b1));
				else
					rsps[rsps.size() - 1].last = 1'b1;
			end
			default: ;   // ignored selector, no state change
		endcase
	endfunction

	// Present one transaction and hold it until the block takes it. The
	// expectation is queued at the edge of acceptance; the results can only
	// come later.
	task automatic issue_cmd(input twq_cmd_t c, input logic has_known,
			input twq_rsp_t known);
		twq_rsp_t rsps[$];
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		predict_queue(c, rsps);
		if (has_known)
			expected_rsp.push_back(known);
		else
			foreach (rsps[i])
				expected_rsp.push_back(rsps[i]);
	endtask

	// Result side: the receiver cannot stall, so every strobe is checked at
	// the edge that ends its cycle against the oldest expectation.
	always @(posedge clk) begin
		twq_rsp_t want;
		if (arst_n && strobe === 1'b1) begin
			if (expected_rsp.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_ERR_LOG)
					$display("%0t: unexpected result status=%0d task=%02h count=%0d last=%0d",
						$time, rsp.status, rsp.out_task, rsp.queue_count, rsp.last);
			end else begin
				want = expected_rsp.pop_front();
				if (rsp.status !== want.status || rsp.out_task !== want.out_task ||
						rsp.queue_count !== want.queue_count || rsp.last !== want.last) begin
					fail_count++;
					if (fail_count <= MAX_ERR_LOG) begin
						$write("%0t: mismatch expected status=%0d task=%02h count=%0d last=%0d",
							$time, want.status, want.out_task, want.queue_count, want.last);
						$display(", got status=%0d task=%02h count=%0d last=%0d",
							rsp.status, rsp.out_task, rsp.queue_count, rsp.last);
					end
				end
			end
		end
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#500_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		twq_cmd_t c;
		int items_sent;
		int mode;
		int mode_left;
		int pick;

		arst_n = 1'b0;
		start  = 1'b0;
		cmd    = '0;

		// Directed part: empty corners, ignored selector, id and timeout
		// extremes, single and multiple release on one tick, untimed
		// entries riding through ticks.
		dir_rows = '{
			'{FUNC_GET,  8'h00, 16'h0000, 1'b1, '{ST_EMPTY,   8'h00, 5'd0, 1'b1}},
			'{FUNC_TICK, 8'h00, 16'h0000, 1'b1, '{ST_NONE,    8'h00, 5'd0, 1'b1}},
			'{FUNC_NOP,  8'hC3, 16'h1234, 1'b0, '0},
			'{FUNC_PUT,  8'hFF, 16'h0000, 1'b1, '{ST_PUT_OK,  8'h00, 5'd1, 1'b1}},
			'{FUNC_PUT,  8'h00, 16'hFFFF, 1'b1, '{ST_PUT_OK,  8'h00, 5'd2, 1'b1}},
			'{FUNC_PUT,  8'hA5, 16'h0001, 1'b1, '{ST_PUT_OK,  8'h00, 5'd3, 1'b1}},
			'{FUNC_PUT,  8'h5A, 16'h0002, 1'b1, '{ST_PUT_OK,  8'h00, 5'd4, 1'b1}},
			'{FUNC_TICK, 8'h00, 16'h0000, 1'b0, '0},
			'{FUNC_TICK, 8'h00, 16'h0000, 1'b0, '0},
			'{FUNC_TICK, 8'h00, 16'h0000, 1'b0, '0},
			'{FUNC_GET,  8'h00, 16'h0000, 1'b0, '0},
			'{FUNC_PUT,  8'h01, 16'h0001, 1'b0, '0},
			'{FUNC_PUT,  8'h02, 16'h0000, 1'b0, '0},
			'{FUNC_PUT,  8'h03, 16'h0001, 1'b0, '0},
			'{FUNC_PUT,  8'h04, 16'h0003, 1'b0, '0},
			'{FUNC_PUT,  8'h05, 16'h0001, 1'b0, '0},
			'{FUNC_TICK, 8'h00, 16'h0000, 1'b0, '0},
			'{FUNC_TICK, 8'h00, 16'h0000, 1'b0, '0},
			'{FUNC_TICK, 8'h00, 16'h0000, 1'b0, '0},
			'{FUNC_GET,  8'h00, 16'h0000, 1'b0, '0},
			'{FUNC_GET,  8'h00, 16'h0000, 1'b0, '0},
			'{FUNC_GET,  8'h00, 16'h0000, 1'b1, '{ST_EMPTY,   8'h00, 5'd0, 1'b1}},
			'{FUNC_PUT,  8'h80, 16'h8000, 1'b1, '{ST_PUT_OK,  8'h00, 5'd1, 1'b1}},
			'{FUNC_PUT,  8'h7F, 16'h7FFF, 1'b1, '{ST_PUT_OK,  8'h00, 5'd2, 1'b1}},
			'{FUNC_GET,  8'h00, 16'h0000, 1'b0, '0}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			c.func       = twq_func_t'(dir_rows[i].func);
			c.task_id    = dir_rows[i].task_id;
			c.wait_ticks = dir_rows[i].wait_ticks;
			issue_cmd(c, dir_rows[i].has_known, dir_rows[i].known_rsp);
			if ($urandom_range(0, 3) == 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end

		// Random part: bursts of churn (mixed put/get/tick with short
		// timeouts so ticks release often), fills to past full, and drains
		// to past empty. A sprinkle of ignored selectors rides along but
		// does not count as an item.
		items_sent = 0;
		mode       = MODE_CHURN;
		mode_left  = 0;
		while (items_sent < RAND_ITEMS) begin
			c.task_id = 8'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 60)
				c.wait_ticks = 16'($urandom_range(1, 4));
			else if (pick < 75)
				c.wait_ticks = 16'd0;
			else if (pick < 85)
				c.wait_ticks = 16'($urandom_range(5, 30));
			else if (pick < 95)
				c.wait_ticks = 16'($urandom);
			else
				c.wait_ticks = 16'hFFFF;

			if ($urandom_range(0, 24) == 0) begin
				c.func = twq_func_t'(FUNC_NOP);
			end else begin
				if (mode_left == 0) begin
					pick = $urandom_range(0, 9);
					if (pick < 6) begin
						mode      = MODE_CHURN;
						mode_left = $urandom_range(10, 25);
					end else if (pick < 8) begin
						mode      = MODE_FILL;
						mode_left = DEPTH + 2;
					end else begin
						mode      = MODE_DRAIN;
						mode_left = DEPTH + 2;
					end
				end
				mode_left--;
				case (mode)
					MODE_FILL: begin
						c.func = FUNC_PUT;
						if (waiters.size() >= DEPTH)
							mode_left = 0;   // this one hits the full queue
					end
					MODE_DRAIN: begin
						c.func = FUNC_GET;
						if (waiters.size() == 0)
							mode_left = 0;   // this one finds it empty
					end
					default: begin
						pick = $urandom_range(0, 99);
						if (pick < 45)
							c.func = FUNC_PUT;
						else if (pick < 70)
							c.func = FUNC_GET;
						else
							c.func = FUNC_TICK;
					end
				endcase
				items_sent++;
			end

			issue_cmd(c, 1'b0, '0);
			if (items_sent < QUIET_FROM && $urandom_range(0, 3) == 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
		start <= 1'b0;

		// drain outstanding results, then watch a full walk for strays
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 4) @(posedge clk);

		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
